// ----- design/bootloader_command_frame_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bootloader command frame parser
// Clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOOTLOADER_COMMAND_FRAME_PARSER_MACROS_SVH
`define BOOTLOADER_COMMAND_FRAME_PARSER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BCFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcfp: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BCFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcfp: assertion failed");

`endif

// ----- design/bcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcfp_pkg
// Types and constants shared by the bootloader command frame parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfp_pkg;

    typedef logic [1:0] action_t;
    typedef logic [2:0] kind_t;

    // Request actions
    localparam action_t ACT_RX_BYTE = 2'd0;
    localparam action_t ACT_DONE    = 2'd1;
    localparam action_t ACT_READ    = 2'd2;

    // Result kinds
    localparam kind_t KIND_TX     = 3'd0;
    localparam kind_t KIND_ERASE  = 3'd1;
    localparam kind_t KIND_WRITE  = 3'd2;
    localparam kind_t KIND_BOOT   = 3'd3;
    localparam kind_t KIND_STAGED = 3'd4;

    // Configuration register indexes
    localparam logic CFG_FLASH_START = 1'b0;
    localparam logic CFG_DEVICE_ID   = 1'b1;

    localparam logic [7:0] DEVICE_ID_RESET = 8'd14;

    // Framing and command bytes
    localparam logic [7:0] SYNC_FIRST  = 8'h75;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CMD_ERASE   = 8'h30;  // '0'
    localparam logic [7:0] CMD_WRITE   = 8'h31;  // '1'
    localparam logic [7:0] CMD_VERSION = 8'h56;  // 'V'
    localparam logic [7:0] CMD_IDENT   = 8'h49;  // 'I'
    localparam logic [7:0] CMD_DEVICE  = 8'h44;  // 'D'
    localparam logic [7:0] CMD_BOOT    = 8'h52;  // 'R'
    localparam logic [7:0] MEM_FLASH   = 8'h46;  // 'F'

    // Answer bytes
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_OK    = 8'h21;  // '!'
    localparam logic [7:0] CH_FAIL  = 8'h2D;  // '-'
    localparam logic [7:0] CH_UNKN  = 8'h3F;  // '?'

    // Signature bytes
    localparam logic [7:0] SIG_0 = 8'h20;
    localparam logic [7:0] SIG_1 = 8'h01;
    localparam logic [7:0] SIG_2 = 8'h05;

endpackage

`default_nettype wire

// ----- design/bcfp_if.sv -----
// ----------------------------------------------------------------------------
// bcfp_cmd_if / bcfp_rsp_if
// Valid/ready channels carrying parser requests and parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcfp_cmd_if;
    logic               valid;
    logic               ready;
    bcfp_pkg::action_t  action;
    logic [7:0]         rx_byte;
    logic               flash_ok;
    logic [7:0]         read_index;

    modport source (output valid, action, rx_byte, flash_ok, read_index, input ready);
    modport sink   (input valid, action, rx_byte, flash_ok, read_index, output ready);
endinterface

interface bcfp_rsp_if;
    logic               valid;
    logic               ready;
    bcfp_pkg::kind_t    kind;
    logic [7:0]         byte_value;
    logic [23:0]        write_address;
    logic [8:0]         write_length;
    logic               last;

    modport source (output valid, kind, byte_value, write_address, write_length, last,
                    input ready);
    modport sink   (input valid, kind, byte_value, write_address, write_length, last,
                    output ready);
endinterface

`default_nettype wire

// ----- design/bootloader_command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// bootloader_command_frame_parser
// Serial bootloader command parser with a staging buffer for write frames.
// ----------------------------------------------------------------------------
// One request per clock is taken on cmd while cmd.ready is high: a received
// byte, a flash completion or a staging buffer read. Requests that answer with
// one result (or none) stream at one per cycle while rsp is not stalled; a 'V'
// or 'I' command holds cmd while its two or three answer bytes are handed to
// rsp one per cycle unless rsp stalls; the answer's burst length sets the rate there.
// Results pass through the answer stage and then the rsp register, and wait
// there while rsp is stalled. Data bytes of a write frame go to a single-port
// synchronous staging RAM of BUFFER_BYTES entries; a staged read gets its data
// from that RAM's registered read port. The RAM is not cleared: reading an
// entry that no frame has written returns whatever it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module bootloader_command_frame_parser #(
    parameter int BUFFER_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data,
    bcfp_cmd_if.sink         cmd,
    bcfp_rsp_if.source       rsp
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CMD, PH_ADDR_H, PH_ADDR_M, PH_ADDR_L,
        PH_LEN_H, PH_LEN_L, PH_MEMTYPE, PH_DATA, PH_CK_LO, PH_CK_HI,
        PH_WAIT_ERASE, PH_WAIT_WRITE
    } phase_t;

    // Answer descriptor held in the answer stage
    typedef enum logic [2:0] {
        RSP_ERASE, RSP_VERSION, RSP_IDENT, RSP_BYTE, RSP_BOOT, RSP_WRITE, RSP_STAGED
    } rsp_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [23:0] flash_start_reg;
    logic [7:0]  device_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_start_reg <= '0;
            device_id_reg   <= bcfp_pkg::DEVICE_ID_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcfp_pkg::CFG_FLASH_START: flash_start_reg <= cfg_data;
                bcfp_pkg::CFG_DEVICE_ID:   device_id_reg   <= cfg_data[7:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    phase_t      phase_reg,   phase_next;
    logic [23:0] addr_reg,    addr_next;
    logic [15:0] len_reg,     len_next;
    logic [7:0]  memtype_reg, memtype_next;
    logic [15:0] count_reg,   count_next;
    logic [24:0] sum_reg,     sum_next;
    logic [7:0]  cklo_reg,    cklo_next;

    // Answer stage
    logic        s1_valid_reg;
    rsp_t        s1_rsp_reg;
    logic [1:0]  s1_cnt_reg;
    logic [7:0]  s1_byte_reg;
    logic [23:0] s1_addr_reg;
    logic [8:0]  s1_len_reg;
    logic        s1_hit_reg;
    logic [1:0]  s1_last_cnt;
    logic        s1_last;
    logic        s1_pop;

    // Output register
    logic        out_valid_reg;
    logic        out_load;
    bcfp_pkg::kind_t out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [23:0] out_addr_reg;
    logic [8:0]  out_len_reg;
    logic        out_last_reg;

    // Staging RAM
    logic [7:0]    mem [BUFFER_BYTES];
    logic          mem_we;
    logic          rd_en;
    logic          rd_hit;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data_reg;

    logic        accept;
    logic        emit;
    rsp_t        emit_rsp;
    logic [7:0]  emit_byte;
    logic [7:0]  b;
    logic [15:0] count_inc;
    logic [24:0] ck_rx;

    // Generated result for the answer stage
    bcfp_pkg::kind_t gen_kind;
    logic [7:0]  gen_byte;
    logic [23:0] gen_addr;
    logic [8:0]  gen_len;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_load  = !out_valid_reg || rsp.ready;
    assign s1_last   = (s1_cnt_reg == s1_last_cnt);
    assign s1_pop    = s1_valid_reg && out_load && s1_last;
    assign cmd.ready = !s1_valid_reg || s1_pop;
    assign accept    = cmd.valid && cmd.ready;

    assign b         = cmd.rx_byte;
    assign count_inc = count_reg + 16'd1;
    assign ck_rx     = {9'd0, b, cklo_reg};
    assign rd_hit    = ({9'd0, cmd.read_index} < BUF_LIMIT);
    assign rd_addr   = AW'(cmd.read_index);

    // ------------------------------------------------------------------
    // Request decode and frame update
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        memtype_next = memtype_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        cklo_next    = cklo_reg;
        emit         = 1'b0;
        emit_rsp     = RSP_BYTE;
        emit_byte    = '0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;

        if (accept)
        begin
            unique case (cmd.action)
                bcfp_pkg::ACT_RX_BYTE:
                begin
                    unique case (phase_reg) inside
                        PH_SYNC1:
                        begin
                            if (b == bcfp_pkg::SYNC_FIRST)
                                phase_next = PH_SYNC2;
                        end
                        PH_SYNC2:
                        begin
                            phase_next = (b == bcfp_pkg::SYNC_SECOND) ? PH_CMD : PH_SYNC1;
                        end
                        PH_CMD:
                        begin
                            phase_next = PH_SYNC1;
                            emit       = 1'b1;
                            unique case (b)
                                bcfp_pkg::CMD_ERASE:
                                begin
                                    emit_rsp   = RSP_ERASE;
                                    phase_next = PH_WAIT_ERASE;
                                end
                                bcfp_pkg::CMD_WRITE:
                                begin
                                    emit       = 1'b0;
                                    sum_next   = '0;
                                    addr_next  = '0;
                                    len_next   = '0;
                                    count_next = '0;
                                    phase_next = PH_ADDR_H;
                                end
                                bcfp_pkg::CMD_VERSION: emit_rsp = RSP_VERSION;
                                bcfp_pkg::CMD_IDENT:   emit_rsp = RSP_IDENT;
                                bcfp_pkg::CMD_DEVICE:  emit_byte = device_id_reg;
                                bcfp_pkg::CMD_BOOT:    emit_rsp = RSP_BOOT;
                                default:               emit_byte = bcfp_pkg::CH_UNKN;
                            endcase
                        end
                        PH_ADDR_H, PH_ADDR_M, PH_ADDR_L:
                        begin
                            addr_next  = {addr_reg[15:0], b};
                            sum_next   = sum_reg + {17'd0, b};
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        PH_LEN_H, PH_LEN_L:
                        begin
                            len_next   = {len_reg[7:0], b};
                            sum_next   = sum_reg + {17'd0, b};
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        PH_MEMTYPE:
                        begin
                            memtype_next = b;
                            sum_next     = sum_reg + {17'd0, b};
                            count_next   = '0;
                            phase_next   = (len_reg == 16'd0) ? PH_CK_LO : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            // bytes past the buffer are summed but not stored
                            mem_we     = ({1'b0, count_reg} < BUF_LIMIT);
                            sum_next   = sum_reg + {17'd0, b};
                            count_next = count_inc;
                            if (count_inc == len_reg)
                                phase_next = PH_CK_LO;
                        end
                        PH_CK_LO:
                        begin
                            cklo_next  = b;
                            phase_next = PH_CK_HI;
                        end
                        PH_CK_HI:
                        begin
                            phase_next = PH_SYNC1;
                            emit       = 1'b1;
                            if (ck_rx != sum_reg || {1'b0, len_reg} > BUF_LIMIT)
                                emit_byte = bcfp_pkg::CH_FAIL;
                            else if (memtype_reg == bcfp_pkg::MEM_FLASH)
                            begin
                                if (addr_reg < flash_start_reg)
                                    emit_byte = bcfp_pkg::CH_OK;
                                else
                                begin
                                    emit_rsp   = RSP_WRITE;
                                    phase_next = PH_WAIT_WRITE;
                                end
                            end
                            else
                                emit_byte = cklo_reg;  // non-flash memtype: echo
                        end
                        default:
                        begin
                            // waiting for a flash completion: byte dropped
                        end
                    endcase
                end
                bcfp_pkg::ACT_DONE:
                begin
                    if (phase_reg == PH_WAIT_ERASE)
                    begin
                        emit       = 1'b1;
                        emit_byte  = bcfp_pkg::CH_OK;
                        phase_next = PH_SYNC1;
                    end
                    else if (phase_reg == PH_WAIT_WRITE)
                    begin
                        emit       = 1'b1;
                        emit_byte  = cmd.flash_ok ? bcfp_pkg::CH_OK : bcfp_pkg::CH_FAIL;
                        phase_next = PH_SYNC1;
                    end
                end
                bcfp_pkg::ACT_READ:
                begin
                    emit     = 1'b1;
                    emit_rsp = RSP_STAGED;
                    rd_en    = rd_hit;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            addr_reg    <= '0;
            len_reg     <= '0;
            memtype_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            cklo_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
            memtype_reg <= memtype_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            cklo_reg    <= cklo_next;
        end
    end

    // ------------------------------------------------------------------
    // Staging RAM: one write or one read per cycle, registered read.
    // A write and a read never come from the same request, and a read in the
    // cycle after a write sees the written byte, so no bypass is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= b;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Answer stage: expands a descriptor into one to three results
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (s1_rsp_reg)
            RSP_VERSION: s1_last_cnt = 2'd1;
            RSP_IDENT:   s1_last_cnt = 2'd2;
            default:     s1_last_cnt = 2'd0;
        endcase
    end

    always_comb
    begin
        gen_kind = bcfp_pkg::KIND_TX;
        gen_byte = '0;
        gen_addr = '0;
        gen_len  = '0;
        unique case (s1_rsp_reg)
            RSP_ERASE:   gen_kind = bcfp_pkg::KIND_ERASE;
            RSP_VERSION: gen_byte = (s1_cnt_reg == 2'd0) ? bcfp_pkg::CH_ZERO : bcfp_pkg::CH_ONE;
            RSP_IDENT:
            begin
                if (s1_cnt_reg == 2'd0)
                    gen_byte = bcfp_pkg::SIG_0;
                else if (s1_cnt_reg == 2'd1)
                    gen_byte = bcfp_pkg::SIG_1;
                else
                    gen_byte = bcfp_pkg::SIG_2;
            end
            RSP_BYTE:    gen_byte = s1_byte_reg;
            RSP_BOOT:    gen_kind = bcfp_pkg::KIND_BOOT;
            RSP_WRITE:
            begin
                gen_kind = bcfp_pkg::KIND_WRITE;
                gen_addr = s1_addr_reg;
                gen_len  = s1_len_reg;
            end
            RSP_STAGED:
            begin
                gen_kind = bcfp_pkg::KIND_STAGED;
                gen_byte = s1_hit_reg ? rd_data_reg : 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= emit;
                s1_cnt_reg   <= '0;
            end
            else if (s1_pop)
                s1_valid_reg <= 1'b0;
            else if (s1_valid_reg && out_load)
                s1_cnt_reg <= s1_cnt_reg + 2'd1;

            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg  <= emit_rsp;
            s1_byte_reg <= emit_byte;
            s1_addr_reg <= addr_reg;
            s1_len_reg  <= len_reg[8:0];
            s1_hit_reg  <= rd_hit;
        end
        if (out_load && s1_valid_reg)
        begin
            out_kind_reg <= gen_kind;
            out_byte_reg <= gen_byte;
            out_addr_reg <= gen_addr;
            out_len_reg  <= gen_len;
            out_last_reg <= s1_last;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.byte_value    = out_byte_reg;
    assign rsp.write_address = out_addr_reg;
    assign rsp.write_length  = out_len_reg;
    assign rsp.last          = out_last_reg;

endmodule

`default_nettype wire

// ----- design/bcfp_checker.sv -----
// ----------------------------------------------------------------------------
// bcfp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bootloader_command_frame_parser_macros.svh"

module bcfp_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire bcfp_pkg::kind_t       rsp_kind,
    input wire logic [7:0]            rsp_byte_value,
    input wire logic [23:0]           rsp_write_address,
    input wire logic [8:0]            rsp_write_length,
    input wire logic                  rsp_last
);

    // stalled result holds
    `BCFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_value) && $stable(rsp_write_address) && $stable(rsp_last))

    // a multi-byte answer is delivered without gaps
    `BCFP_ASSERT_NEXT(a_rsp_burst, rsp_valid && !rsp_last, rsp_valid)

    // only transmit bytes come in bursts
    `BCFP_ASSERT_NOW(a_rsp_single, rsp_valid && (rsp_kind != bcfp_pkg::KIND_TX), rsp_last)

    // address and length only on write requests
    `BCFP_ASSERT_NOW(a_rsp_wfields, rsp_valid && (rsp_kind != bcfp_pkg::KIND_WRITE), rsp_write_address == 24'd0 && rsp_write_length == 9'd0)

endmodule

bind bootloader_command_frame_parser bcfp_checker u_bcfp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_kind          (rsp.kind),
    .rsp_byte_value    (rsp.byte_value),
    .rsp_write_address (rsp.write_address),
    .rsp_write_length  (rsp.write_length),
    .rsp_last          (rsp.last)
);

`default_nettype wire
